>>> sv/ctr_pkg.sv
// shared types and constants for the columnar transposition block
`default_nettype none

package ctr_pkg;

    // sequencer states
    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SIZE,
        ST_RD,
        ST_FILL
    } ctr_state_t;

    // byte emitted for grid cells past the end of the message
    localparam logic [7:0] PAD_CHAR = 8'h20;

endpackage : ctr_pkg

`default_nettype wire

>>> sv/ctr_ram.sv
// generic single-port-write, single-port-read ram with registered read data
`default_nettype none

module ctr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // read port, registered read data
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule : ctr_ram

`default_nettype wire

>>> sv/ctr_size.sv
// grid sizing unit: iterative integer square root, then rows and columns
`default_nettype none

module ctr_size #(
    parameter int CNT_W = 7,
    parameter int DIM_W = 5,
    parameter int IDX_W = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [CNT_W-1:0] len,
    output logic                  done,
    output logic      [DIM_W-1:0] rows,
    output logic      [DIM_W-1:0] cols
);

    logic [DIM_W-1:0] root_reg;
    logic [DIM_W-1:0] root_next;
    logic [IDX_W-1:0] sq_reg;
    logic [IDX_W-1:0] sq_next;
    logic             busy_reg;
    logic             busy_next;

    logic [IDX_W-1:0] len_ext;
    logic [IDX_W-1:0] odd;
    logic [IDX_W-1:0] nsq;
    logic [IDX_W-1:0] prod;
    logic             exact;

    // next square is (root+1)^2 = root^2 + 2*root + 1
    assign len_ext = IDX_W'(len);
    assign odd     = IDX_W'({root_reg, 1'b1});
    assign nsq     = sq_reg + odd;
    assign done    = busy_reg && (nsq > len_ext);

    // grid shape from the floor root
    assign exact = (sq_reg == len_ext);
    assign cols  = exact ? root_reg : root_reg + DIM_W'(1);
    assign prod  = exact ? sq_reg : sq_reg + IDX_W'(root_reg);
    assign rows  = (prod < len_ext) ? root_reg + DIM_W'(1) : root_reg;

    // root search step
    always_comb
    begin
        root_next = root_reg;
        sq_next   = sq_reg;
        busy_next = busy_reg;
        if (start)
        begin
            root_next = '0;
            sq_next   = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (done)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                root_next = root_reg + DIM_W'(1);
                sq_next   = nsq;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_reg <= '0;
            sq_reg   <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            root_reg <= root_next;
            sq_reg   <= sq_next;
            busy_reg <= busy_next;
        end
    end

`ifndef SYNTHESIS
    // the search never overshoots the length
    a_sq_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (sq_reg <= len_ext))
        else $error("root search passed the length");

    // the grid always holds the whole message
    a_grid_fits: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (({{DIM_W{1'b0}}, rows} * {{DIM_W{1'b0}}, cols})
                  >= (2*DIM_W)'(len)))
        else $error("grid smaller than message");
`endif

endmodule : ctr_size

`default_nettype wire

>>> sv/columnar_transposition_top.sv
// columnar transposition: byte buffer in ram, grid sizing and cell sequencer
//
//  channel  | handshake         | payload           | note
//  ---------+-------------------+-------------------+------------------------------
//  input    | in_valid/in_stall | char_in, last_in  | one message byte per beat
//  output   | out_valid/out_st. | char_out,last_out | one grid cell per beat
//  config   | cfg_we            | cfg_data          | decrypt_mode, no read-back
//
// loading accepts a byte whenever in_valid is high; after the last byte the root search
// runs, then each grid cell is read from ram (ST_RD, waiting while the output is stalled)
// and put in the output register (ST_FILL), rows*cols cells in all. in_stall is high from
// the last byte until the final cell is in the output register. no clearing pass after reset:
// only entries this message wrote reach char_out; cells past the end are padded.
`default_nettype none

module columnar_transposition_top
    import ctr_pkg::*;
#(
    parameter int MAX_LEN = 64
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic       cfg_data,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] char_in,
    input  wire logic       last_in,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic      [7:0] char_out,
    output logic            last_out
);

    localparam int CNT_W  = $clog2(MAX_LEN + 1);
    localparam int ADDR_W = $clog2(MAX_LEN);
    localparam int IDX_W  = $clog2(2 * MAX_LEN + 1);
    localparam int DIM_W  = (CNT_W + 1) / 2 + 1;

    ctr_state_t state_reg;
    ctr_state_t state_next;

    logic             mode_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] len_reg;
    logic [DIM_W-1:0] inner_lim_reg;
    logic [DIM_W-1:0] outer_lim_reg;
    logic [DIM_W-1:0] stride_reg;
    logic [DIM_W-1:0] in_cnt_reg;
    logic [DIM_W-1:0] out_cnt_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             pad_reg;
    logic             out_valid_reg;
    logic [7:0]       char_out_reg;
    logic             last_out_reg;

    logic             in_acc;
    logic             out_free;
    logic             room;
    logic             size_start;
    logic             size_done;
    logic [DIM_W-1:0] size_rows;
    logic [DIM_W-1:0] size_cols;
    logic             ram_we;
    logic             ram_re;
    logic [7:0]       ram_rdata;
    logic [IDX_W-1:0] len_ext;
    logic             inner_end;
    logic             fill_last;

    assign in_acc    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign room      = (count_reg < CNT_W'(MAX_LEN));
    assign len_ext   = IDX_W'(len_reg);
    assign inner_end = (in_cnt_reg == inner_lim_reg - DIM_W'(1));
    assign fill_last = inner_end && (out_cnt_reg == outer_lim_reg - DIM_W'(1));

    // message buffer
    ctr_ram #(
        .WIDTH (8),
        .DEPTH (MAX_LEN)
    ) u_buf (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (char_in),
        .re    (ram_re),
        .raddr (idx_reg[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    // grid sizing
    ctr_size #(
        .CNT_W (CNT_W),
        .DIM_W (DIM_W),
        .IDX_W (IDX_W)
    ) u_size (
        .clk   (clk),
        .rst_n (rst_n),
        .start (size_start),
        .len   (len_reg),
        .done  (size_done),
        .rows  (size_rows),
        .cols  (size_cols)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_acc && last_in)
                begin
                    state_next = ST_SIZE;
                end
            end
            ST_SIZE:
            begin
                if (size_done)
                begin
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                if (out_free)
                begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL:
            begin
                state_next = fill_last ? ST_LOAD : ST_RD;
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        in_stall   = 1'b1;
        size_start = 1'b0;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        unique case (state_reg)
            ST_LOAD:
            begin
                in_stall   = 1'b0;
                size_start = in_valid && last_in;
                ram_we     = in_valid && room;
            end
            ST_SIZE:
            begin
                in_stall = 1'b1;
            end
            ST_RD:
            begin
                ram_re = out_free;
            end
            ST_FILL:
            begin
                in_stall = 1'b1;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // state, mode and byte count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            mode_reg  <= 1'b0;
            count_reg <= '0;
            len_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                mode_reg <= cfg_data;
            end
            if (in_acc)
            begin
                if (last_in)
                begin
                    len_reg   <= room ? count_reg + CNT_W'(1) : count_reg;
                    count_reg <= '0;
                end
                else if (room)
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
            end
        end
    end

    // cell walk: inner counter steps the index by the stride, outer restarts it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inner_lim_reg <= '0;
            outer_lim_reg <= '0;
            stride_reg    <= '0;
            in_cnt_reg    <= '0;
            out_cnt_reg   <= '0;
            idx_reg       <= '0;
            pad_reg       <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_SIZE && size_done)
            begin
                in_cnt_reg  <= '0;
                out_cnt_reg <= '0;
                idx_reg     <= '0;
                if (mode_reg)
                begin
                    inner_lim_reg <= size_cols;
                    outer_lim_reg <= size_rows;
                    stride_reg    <= size_rows;
                end
                else
                begin
                    inner_lim_reg <= size_rows;
                    outer_lim_reg <= size_cols;
                    stride_reg    <= size_cols;
                end
            end
            if (ram_re)
            begin
                pad_reg <= !(idx_reg < len_ext);
            end
            if (state_reg == ST_FILL)
            begin
                if (inner_end)
                begin
                    in_cnt_reg  <= '0;
                    out_cnt_reg <= out_cnt_reg + DIM_W'(1);
                    idx_reg     <= IDX_W'(out_cnt_reg) + IDX_W'(1);
                end
                else
                begin
                    in_cnt_reg <= in_cnt_reg + DIM_W'(1);
                    idx_reg    <= idx_reg + IDX_W'(stride_reg);
                end
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == ST_FILL)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_FILL)
        begin
            char_out_reg <= pad_reg ? PAD_CHAR : ram_rdata;
            last_out_reg <= fill_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign char_out  = char_out_reg;
    assign last_out  = last_out_reg;

`ifndef SYNTHESIS
    // the byte count never passes the buffer size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_LEN))
        else $error("byte count beyond buffer");

    // walk counters stay inside the grid
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FILL) |->
            (in_cnt_reg < inner_lim_reg) && (out_cnt_reg < outer_lim_reg))
        else $error("cell walk left the grid");

    // a real message byte is always inside the buffer
    a_read_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_re && (idx_reg < len_ext)) |-> (idx_reg < IDX_W'(MAX_LEN)))
        else $error("buffer read out of range");

    // the final cell carries the end mark and frees the input
    a_last_cell: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FILL && fill_last) |=>
            (state_reg == ST_LOAD) && out_valid_reg && last_out_reg)
        else $error("final cell not marked");
`endif

endmodule : columnar_transposition_top

`default_nettype wire
